// ===== hdl/gwt_pkg.sv =====
package gwt_pkg;

  localparam int MOV_W    = 8;
  localparam int DUR_W    = 8;
  localparam int IDX_W    = 3;
  localparam int POS_W    = 11;
  localparam int TIME_W   = 12;
  localparam int SECS_W   = 12;
  localparam int WIN_W    = 3;
  localparam int CYC_W    = 11;
  localparam int STAT_W   = 2;
  localparam int WIDX_W   = 4;
  localparam int ENTRY_W  = MOV_W + DUR_W;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [SECS_W-1:0] SECS_MAX = {SECS_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic RING_A = 1'b0;
  localparam logic RING_B = 1'b1;

  localparam logic REG_TARGET = 1'b0;

  localparam logic [MOV_W-1:0] TARGET_RST = 8'd1;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOTH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_PAST = 2'd3;

  typedef struct packed {
    logic              hit;
    logic              found;
    logic              green;
    logic [TIME_W-1:0] delta;
    logic [WIDX_W-1:0] widx;
    logic [TIME_W-1:0] first_on;
    logic [TIME_W-1:0] total;
  } ring_res_t;

endpackage

// ===== hdl/gwt_in_if.sv =====
interface gwt_in_if;
  import gwt_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic             ring;
  logic [IDX_W-1:0] phase_index;
  logic [MOV_W-1:0] movement_code;
  logic [DUR_W-1:0] phase_duration;
  logic [POS_W-1:0] cycle_position;

  modport source (
    output valid, operation, ring, phase_index, movement_code, phase_duration,
           cycle_position,
    input  ready
  );

  modport sink (
    input  valid, operation, ring, phase_index, movement_code, phase_duration,
           cycle_position,
    output ready
  );

endinterface

// ===== hdl/gwt_out_if.sv =====
interface gwt_out_if;
  import gwt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              is_green;
  logic [SECS_W-1:0] seconds_to_change;
  logic [WIN_W-1:0]  window_index;
  logic [CYC_W-1:0]  cycle_length;

  modport source (
    output valid, status, is_green, seconds_to_change, window_index, cycle_length,
    input  ready
  );

  modport sink (
    input  valid, status, is_green, seconds_to_change, window_index, cycle_length,
    output ready
  );

endinterface

// ===== hdl/gwt_ring_mem.sv =====
module gwt_ring_mem #(
  parameter int PHASES_PER_RING = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               we,
  input  logic [$clog2(PHASES_PER_RING)-1:0] waddr,
  input  logic [gwt_pkg::ENTRY_W-1:0]        wdata,
  input  logic                               re,
  input  logic [$clog2(PHASES_PER_RING)-1:0] raddr,
  output logic [gwt_pkg::ENTRY_W-1:0]        rdata
);
  import gwt_pkg::*;

  logic [ENTRY_W-1:0]         mem [PHASES_PER_RING];
  logic [PHASES_PER_RING-1:0] vld_r;
  logic [ENTRY_W-1:0]         rdata_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gwt_window_scan.sv =====
module gwt_window_scan #(
  parameter int PHASES_PER_RING = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      step,
  input  logic                      fin,
  input  logic [gwt_pkg::MOV_W-1:0] target,
  input  logic [gwt_pkg::POS_W-1:0] pos,
  input  logic [gwt_pkg::MOV_W-1:0] mov,
  input  logic [gwt_pkg::DUR_W-1:0] dur,
  output gwt_pkg::ring_res_t        res
);
  import gwt_pkg::*;

  localparam int IW = $clog2(PHASES_PER_RING);

  logic              open_r, open_nxt;
  logic              hit_r, hit_nxt;
  logic              found_r, found_nxt;
  logic              green_r, green_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [TIME_W-1:0] on_r, on_nxt;
  logic [TIME_W-1:0] off_r, off_nxt;
  logic [TIME_W-1:0] first_on_r, first_on_nxt;
  logic [TIME_W-1:0] delta_r, delta_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     widx_r, widx_nxt;
  logic              chk_en;
  logic [TIME_W-1:0] pos_t;
  logic [TIME_W-1:0] t_end;

  assign pos_t = TIME_W'(pos);
  assign t_end = t_r + TIME_W'(dur);

  always_comb begin
    open_nxt     = open_r;
    hit_nxt      = hit_r;
    found_nxt    = found_r;
    green_nxt    = green_r;
    t_nxt        = t_r;
    on_nxt       = on_r;
    off_nxt      = off_r;
    first_on_nxt = first_on_r;
    delta_nxt    = delta_r;
    idx_nxt      = idx_r;
    widx_nxt     = widx_r;
    chk_en       = 1'b0;

    if (clear) begin
      open_nxt  = 1'b0;
      hit_nxt   = 1'b0;
      found_nxt = 1'b0;
      green_nxt = 1'b0;
      t_nxt     = '0;
      delta_nxt = '0;
      widx_nxt  = '0;
    end else if (step) begin
      if (mov == target) begin
        hit_nxt = 1'b1;
        if (open_r && off_r == t_r) begin
          off_nxt = t_end;
        end else begin
          // close the previous window and open a new one
          chk_en  = open_r;
          on_nxt  = t_r;
          off_nxt = t_end;
          idx_nxt = open_r ? idx_r + 1'b1 : '0;
          if (!open_r) begin
            first_on_nxt = t_r;
          end
          open_nxt = 1'b1;
        end
      end
      t_nxt = t_end;
    end else if (fin) begin
      chk_en = open_r;
    end

    if (chk_en && !found_r) begin
      if (pos_t >= on_r && pos_t < off_r) begin
        found_nxt = 1'b1;
        green_nxt = 1'b1;
        delta_nxt = off_r - pos_t;
        widx_nxt  = idx_r;
      end else if (pos_t < on_r) begin
        found_nxt = 1'b1;
        delta_nxt = on_r - pos_t;
        widx_nxt  = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      open_r  <= open_nxt;
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    green_r    <= green_nxt;
    t_r        <= t_nxt;
    on_r       <= on_nxt;
    off_r      <= off_nxt;
    first_on_r <= first_on_nxt;
    delta_r    <= delta_nxt;
    idx_r      <= idx_nxt;
    widx_r     <= widx_nxt;
  end

  assign res.hit      = hit_r;
  assign res.found    = found_r;
  assign res.green    = green_r;
  assign res.delta    = delta_r;
  assign res.widx     = WIDX_W'(widx_r);
  assign res.first_on = first_on_r;
  assign res.total    = t_r;

endmodule

// ===== hdl/signal_phase_green_window_timer_unit.sv =====
// green window timer for a two-ring signal plan
//
// in_req: valid/ready request channel; operation load writes one phase
// (movement code and duration) of ring A or B, operation query asks about
// a cycle position. out_rsp: valid/ready channel with one response per
// query and none per load. cfg: apb-style port, target_movement at 0x0.
//
// a load is taken only while the block is idle. a query reads both ring
// memories in parallel, one phase entry per cycle, and both rings run their
// window scan side by side through the scan, drain, finish and result states.
// no new request is taken until the result is written to the output
// register, so a query is not taken before the last one is through; the
// memory read port, one entry per cycle, limits the query throughput.
//
// reset clears both plans to all zeros (valid bit per entry) and sets the
// target movement to 1; the block is ready the cycle after reset.
// the response sits in an output register: new requests are taken while it
// waits, and a following query holds its result until the register frees.
module signal_phase_green_window_timer_unit #(
  parameter int PHASES_PER_RING = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gwt_in_if.sink                     in_req,
  gwt_out_if.source                  out_rsp,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [gwt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [gwt_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [gwt_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import gwt_pkg::*;

  localparam int AW = $clog2(PHASES_PER_RING);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PHASES_PER_RING - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN, S_RES} state_t;

  state_t            state_r;
  logic [AW-1:0]     addr_r;
  logic              rd_vld_r;
  logic [POS_W-1:0]  pos_r;
  logic [MOV_W-1:0]  target_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic              green_r;
  logic [SECS_W-1:0] secs_r;
  logic [WIN_W-1:0]  widx_r;
  logic [CYC_W-1:0]  cyc_r;

  logic              in_acc;
  logic              load_ok;
  logic              we_a, we_b;
  logic [AW-1:0]     waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata_a, rdata_b;
  logic              scan_clear;
  ring_res_t         res_a, res_b, sel;
  logic              slot_free;
  logic              cfg_wr;

  logic [STAT_W-1:0] status_nxt;
  logic              green_nxt;
  logic [SECS_W-1:0] secs_nxt;
  logic [WIN_W-1:0]  widx_nxt;
  logic [CYC_W-1:0]  cyc_nxt;
  logic [TIME_W:0]   wrap;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign load_ok      = in_acc && in_req.operation == OP_LOAD &&
                        (5'(in_req.phase_index) < 5'(PHASES_PER_RING));
  assign we_a         = load_ok && in_req.ring == RING_A;
  assign we_b         = load_ok && in_req.ring == RING_B;
  assign waddr        = AW'(in_req.phase_index);
  assign wdata        = {in_req.movement_code, in_req.phase_duration};
  assign scan_clear   = in_acc && in_req.operation == OP_QUERY;

  gwt_ring_mem #(.PHASES_PER_RING(PHASES_PER_RING)) u_mem_a (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (state_r == S_SCAN),
    .raddr (addr_r),
    .rdata (rdata_a)
  );

  gwt_ring_mem #(.PHASES_PER_RING(PHASES_PER_RING)) u_mem_b (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (state_r == S_SCAN),
    .raddr (addr_r),
    .rdata (rdata_b)
  );

  gwt_window_scan #(.PHASES_PER_RING(PHASES_PER_RING)) u_scan_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (scan_clear),
    .step   (rd_vld_r),
    .fin    (state_r == S_FIN),
    .target (target_r),
    .pos    (pos_r),
    .mov    (rdata_a[ENTRY_W-1:DUR_W]),
    .dur    (rdata_a[DUR_W-1:0]),
    .res    (res_a)
  );

  gwt_window_scan #(.PHASES_PER_RING(PHASES_PER_RING)) u_scan_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (scan_clear),
    .step   (rd_vld_r),
    .fin    (state_r == S_FIN),
    .target (target_r),
    .pos    (pos_r),
    .mov    (rdata_b[ENTRY_W-1:DUR_W]),
    .dur    (rdata_b[DUR_W-1:0]),
    .res    (res_b)
  );

  // response from the ring that holds the target
  assign sel  = res_a.hit ? res_a : res_b;
  assign wrap = (TIME_W+1)'(sel.total) - (TIME_W+1)'(pos_r) + (TIME_W+1)'(sel.first_on);

  always_comb begin
    status_nxt = STAT_OK;
    green_nxt  = 1'b0;
    secs_nxt   = '0;
    widx_nxt   = '0;
    cyc_nxt    = '0;
    if (res_a.hit && res_b.hit) begin
      status_nxt = STAT_BOTH;
    end else if (!res_a.hit && !res_b.hit) begin
      status_nxt = STAT_NONE;
    end else begin
      cyc_nxt = sel.total[CYC_W-1:0];
      if (TIME_W'(pos_r) >= sel.total) begin
        status_nxt = STAT_PAST;
      end else if (sel.found) begin
        green_nxt = sel.green;
        secs_nxt  = sel.delta;
        widx_nxt  = sel.widx[WIN_W-1:0];
      end else begin
        secs_nxt = (wrap > (TIME_W+1)'(SECS_MAX)) ? SECS_MAX : wrap[SECS_W-1:0];
      end
    end
  end

  assign slot_free = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN);
      if (state_r == S_RES && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (scan_clear) begin
            pos_r   <= in_req.cycle_position;
            addr_r  <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST_ADDR) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= S_RES;
        end
        S_RES: begin
          if (slot_free) begin
            status_r    <= status_nxt;
            green_r     <= green_nxt;
            secs_r      <= secs_nxt;
            widx_r      <= widx_nxt;
            cyc_r       <= cyc_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.status            = status_r;
  assign out_rsp.is_green          = green_r;
  assign out_rsp.seconds_to_change = secs_r;
  assign out_rsp.window_index      = widx_r;
  assign out_rsp.cycle_length      = cyc_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_TARGET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
    end else if (cfg_wr) begin
      target_r <= cfg_pwdata[MOV_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TARGET) ? CFG_DW'(target_r) : '0;

endmodule

// ===== hdl/gwt_checker.sv =====
module gwt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_operation,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gwt_pkg::STAT_W-1:0] out_status,
  input logic                       out_is_green,
  input logic [gwt_pkg::SECS_W-1:0] out_seconds_to_change,
  input logic [gwt_pkg::WIN_W-1:0]  out_window_index,
  input logic [gwt_pkg::CYC_W-1:0]  out_cycle_length
);
  import gwt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_is_green) && $stable(out_seconds_to_change) &&
      $stable(out_window_index) && $stable(out_cycle_length))
    else $error("response changed while stalled");

  a_flag_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |->
      !out_is_green && out_seconds_to_change == '0 && out_window_index == '0)
    else $error("flagged response carries window data");

  a_ring_fault_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_BOTH || out_status == STAT_NONE) |->
      out_cycle_length == '0)
    else $error("ring fault with nonzero cycle length");

  a_ok_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK |-> out_seconds_to_change != '0)
    else $error("ok response with zero wait");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load produced a response");

endmodule

bind signal_phase_green_window_timer_unit gwt_checker u_gwt_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_req.valid),
  .in_ready              (in_req.ready),
  .in_operation          (in_req.operation),
  .out_valid             (out_rsp.valid),
  .out_ready             (out_rsp.ready),
  .out_status            (out_rsp.status),
  .out_is_green          (out_rsp.is_green),
  .out_seconds_to_change (out_rsp.seconds_to_change),
  .out_window_index      (out_rsp.window_index),
  .out_cycle_length      (out_rsp.cycle_length)
);

// ===== test/signal_phase_green_window_timer_unit_test.sv =====
module signal_phase_green_window_timer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gwt_pkg::*;

  localparam int PHASES = 8;
  localparam int DEPTH = 2 * PHASES;
  localparam int SETTLE_CYCLES = 2 * PHASES + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_RUN = 100;

  typedef struct packed {
    logic             op;
    logic             ring;
    logic [IDX_W-1:0] idx;
    logic [MOV_W-1:0] mov;
    logic [DUR_W-1:0] dur;
    logic [POS_W-1:0] pos;
  } phase_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              green;
    logic [SECS_W-1:0] secs;
    logic [WIN_W-1:0]  widx;
    logic [CYC_W-1:0]  cyc;
  } window_rsp_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  gwt_in_if  in_req();
  gwt_out_if out_rsp();

  signal_phase_green_window_timer_unit #(
    .PHASES_PER_RING(PHASES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_rsp    (out_rsp),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  phase_req_t  pending_reqs[$];
  window_rsp_t window_rsp_q[$];
  phase_req_t  driven_req;

  // predicted plan, ring B in the upper half
  logic [MOV_W-1:0] plan_mov [DEPTH] = '{default: '0};
  logic [DUR_W-1:0] plan_dur [DEPTH] = '{default: '0};
  logic [MOV_W-1:0] target_mov;

  // plan as the generator has queued it
  logic [MOV_W-1:0] gen_mov [DEPTH];
  logic [DUR_W-1:0] gen_dur [DEPTH];
  logic [MOV_W-1:0] gen_target;

  int send_idle_pct;
  int rcv_stall_pct;
  int mismatches = 0;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  function automatic window_rsp_t predict_green_window(input logic [POS_W-1:0] pos);
    int unsigned on_t [PHASES];
    int unsigned off_t [PHASES];
    int unsigned nwin;
    int unsigned t;
    int unsigned d;
    int unsigned base;
    int unsigned secs;
    int          i;
    bit          in_a;
    bit          in_b;
    bit          found;
    window_rsp_t r;
    r = '0;
    nwin = 0;
    t = 0;
    secs = 0;
    found = 1'b0;
    in_a = 1'b0;
    in_b = 1'b0;
    for (i = 0; i < PHASES; i++) begin
      in_a |= (plan_mov[i] == target_mov);
      in_b |= (plan_mov[PHASES + i] == target_mov);
    end
    if (in_a && in_b) begin
      r.status = STAT_BOTH;
    end else if (!in_a && !in_b) begin
      r.status = STAT_NONE;
    end else begin
      base = in_a ? 0 : PHASES;
      for (i = 0; i < PHASES; i++) begin
        d = plan_dur[base + i];
        if (plan_mov[base + i] == target_mov) begin
          // touching target phases extend the open window
          if (nwin > 0 && off_t[nwin - 1] == t) begin
            off_t[nwin - 1] = t + d;
          end else begin
            on_t[nwin] = t;
            off_t[nwin] = t + d;
            nwin++;
          end
        end
        t += d;
      end
      r.cyc = CYC_W'(t);
      if (pos >= t) begin
        r.status = STAT_PAST;
      end else begin
        r.status = STAT_OK;
        for (i = 0; i < nwin && !found; i++) begin
          if (pos >= on_t[i] && pos < off_t[i]) begin
            r.green = 1'b1;
            secs = off_t[i] - pos;
            r.widx = WIN_W'(i);
            found = 1'b1;
          end else if (pos < on_t[i]) begin
            secs = on_t[i] - pos;
            r.widx = WIN_W'(i);
            found = 1'b1;
          end
        end
        // past the last window: wait wraps to window 0
        if (!found) begin
          secs = t - pos + on_t[0];
          r.widx = '0;
        end
        if (secs > SECS_MAX) secs = SECS_MAX;
        r.secs = SECS_W'(secs);
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid          <= 1'b0;
      in_req.operation      <= OP_LOAD;
      in_req.ring           <= RING_A;
      in_req.phase_index    <= '0;
      in_req.movement_code  <= '0;
      in_req.phase_duration <= '0;
      in_req.cycle_position <= '0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        if (driven_req.op == OP_LOAD) begin
          plan_mov[{driven_req.ring, driven_req.idx}] = driven_req.mov;
          plan_dur[{driven_req.ring, driven_req.idx}] = driven_req.dur;
        end else begin
          window_rsp_q.push_back(predict_green_window(driven_req.pos));
        end
      end
      if (!in_req.valid || in_req.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_req = pending_reqs.pop_front();
          in_req.valid          <= 1'b1;
          in_req.operation      <= driven_req.op;
          in_req.ring           <= driven_req.ring;
          in_req.phase_index    <= driven_req.idx;
          in_req.movement_code  <= driven_req.mov;
          in_req.phase_duration <= driven_req.dur;
          in_req.cycle_position <= driven_req.pos;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    window_rsp_t exp_rsp;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (window_rsp_q.size() == 0) begin
          $error("response with no query outstanding");
          mismatches++;
        end else begin
          exp_rsp = window_rsp_q.pop_front();
          if (out_rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, out_rsp.status);
            mismatches++;
          end
          if (out_rsp.is_green !== exp_rsp.green) begin
            $error("is_green: expected %0d, actual %0d", exp_rsp.green, out_rsp.is_green);
            mismatches++;
          end
          if (out_rsp.seconds_to_change !== exp_rsp.secs) begin
            $error("seconds_to_change: expected %0d, actual %0d", exp_rsp.secs,
                   out_rsp.seconds_to_change);
            mismatches++;
          end
          if (out_rsp.window_index !== exp_rsp.widx) begin
            $error("window_index: expected %0d, actual %0d", exp_rsp.widx,
                   out_rsp.window_index);
            mismatches++;
          end
          if (out_rsp.cycle_length !== exp_rsp.cyc) begin
            $error("cycle_length: expected %0d, actual %0d", exp_rsp.cyc,
                   out_rsp.cycle_length);
            mismatches++;
          end
        end
      end
      out_rsp.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_load(input logic ring, input logic [IDX_W-1:0] idx,
                           input logic [MOV_W-1:0] mov, input logic [DUR_W-1:0] dur);
    phase_req_t req;
    req = '0;
    req.op = OP_LOAD;
    req.ring = ring;
    req.idx = idx;
    req.mov = mov;
    req.dur = dur;
    req.pos = POS_W'($urandom_range(2047));
    pending_reqs.push_back(req);
    gen_mov[{ring, idx}] = mov;
    gen_dur[{ring, idx}] = dur;
  endtask

  task automatic push_query(input logic [POS_W-1:0] pos);
    phase_req_t req;
    req = '0;
    req.op = OP_QUERY;
    req.ring = 1'($urandom_range(1));
    req.idx = IDX_W'($urandom_range(7));
    req.mov = MOV_W'($urandom_range(255));
    req.dur = DUR_W'($urandom_range(255));
    req.pos = pos;
    pending_reqs.push_back(req);
  endtask

  function automatic int unsigned planned_cycle();
    int unsigned sum;
    int          base;
    int          i;
    sum = 0;
    base = PHASES;
    for (i = 0; i < PHASES; i++) begin
      if (gen_mov[i] == gen_target) base = 0;
    end
    for (i = 0; i < PHASES; i++) sum += gen_dur[base + i];
    return sum;
  endfunction

  function automatic logic [MOV_W-1:0] other_code();
    logic [MOV_W-1:0] c;
    do begin
      c = ($urandom_range(3) == 0) ? MOV_W'($urandom_range(255)) : MOV_W'($urandom_range(1, 8));
    end while (c == gen_target);
    return c;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(9))
      0, 1: return '0;
      2: return '1;
      default: return DUR_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned cyc;
    cyc = planned_cycle();
    case ($urandom_range(9))
      0, 1: return POS_W'($urandom_range(2047));
      2: return (cyc == 0) ? '0 : POS_W'(cyc - 1);
      3: return POS_W'(cyc);
      default: return POS_W'($urandom_range(cyc));
    endcase
  endfunction

  // at most one ring holds the target, the other never does
  task automatic push_plan();
    logic sel;
    int   i;
    sel = 1'($urandom_range(1));
    for (i = 0; i < PHASES; i++) begin
      push_load(sel, IDX_W'(i), ($urandom_range(99) < 40) ? gen_target : other_code(),
                pick_duration());
    end
    for (i = 0; i < PHASES; i++) begin
      push_load(!sel, IDX_W'(i), other_code(), pick_duration());
    end
    repeat ($urandom_range(3, 8)) push_query(pick_position());
  endtask

  task automatic push_noise();
    if ($urandom_range(1)) begin
      push_load(1'($urandom_range(1)), IDX_W'($urandom_range(7)),
                ($urandom_range(3) == 0) ? gen_target : MOV_W'($urandom_range(255)),
                DUR_W'($urandom_range(255)));
    end else begin
      push_query(POS_W'($urandom_range(2047)));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_req.valid || window_rsp_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_target(input logic [MOV_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TARGET, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    target_mov = value;
    gen_target = value;
    @(negedge clk);
  endtask

  initial begin
    int               run;
    int               i;
    int               idle_set [4];
    int               stall_set [4];
    logic [MOV_W-1:0] target_set [4];
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    target_mov = TARGET_RST;
    gen_target = TARGET_RST;
    for (i = 0; i < DEPTH; i++) begin
      gen_mov[i] = '0;
      gen_dur[i] = '0;
    end
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    idle_set = '{0, 49, 0, 10};
    stall_set = '{0, 0, 49, 10};
    target_set = '{TARGET_RST, MOV_W'($urandom_range(2, 254)), '1, '0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // target in neither ring after reset
    push_query('0);
    // ring A: merge across a zero-length phase, empty window, wrap at the end
    push_load(RING_A, 3'd0, 8'd1, 8'd10);
    push_load(RING_A, 3'd1, 8'd2, 8'd0);
    push_load(RING_A, 3'd2, 8'd1, 8'd5);
    push_load(RING_A, 3'd3, 8'd3, 8'd20);
    push_load(RING_A, 3'd4, 8'd1, 8'd0);
    push_load(RING_A, 3'd5, 8'd4, 8'd255);
    push_load(RING_A, 3'd6, 8'd1, 8'd255);
    push_load(RING_A, 3'd7, 8'd255, 8'd255);
    push_query(11'd0);
    push_query(11'd14);
    push_query(11'd15);
    push_query(11'd35);
    push_query(11'd799);
    push_query(11'd2047);
    // target in both rings
    push_load(RING_B, 3'd0, 8'd1, 8'd1);
    push_query(11'd5);
    push_load(RING_B, 3'd0, 8'd0, 8'd0);
    wait_idle();
    write_target('1);
    push_query(11'd600);
    push_query(11'd0);
    wait_idle();
    // code 0 matches the empty ring B, cycle length 0
    write_target('0);
    push_query(11'd0);

    for (run = 0; run < 4; run++) begin
      wait_idle();
      send_idle_pct = idle_set[run];
      rcv_stall_pct = stall_set[run];
      write_target(target_set[run]);
      while (pending_reqs.size() < ITEMS_PER_RUN) begin
        if ($urandom_range(99) < 80) begin
          push_plan();
        end else begin
          repeat ($urandom_range(1, 4)) push_noise();
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== signal_phase_green_window_timer_unit.f =====
hdl/gwt_pkg.sv
hdl/gwt_in_if.sv
hdl/gwt_out_if.sv
hdl/gwt_ring_mem.sv
hdl/gwt_window_scan.sv
hdl/signal_phase_green_window_timer_unit.sv
hdl/gwt_checker.sv
test/signal_phase_green_window_timer_unit_test.sv
